FILE: rtl/core/mwa_pkg.sv
// Shared types for the maximum-weight assignment subset DP block.
// Field widths and the controller/datapath command and status words.
// No dependencies.
package mwa_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned WGT_W  = 32;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned OUT_W  = 35;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic load;      // input word accepted
    logic start;     // begin subset walk
    logic issue;     // read one column's operands
    logic write;     // store best of current mask
    logic advance;   // step to next mask
    logic out_load;  // capture full-mask result
  } cmd_t;

  typedef struct packed {
    logic col_last;
    logic mask_last;
  } sts_t;

endpackage

FILE: rtl/core/max_weight_assignment_subset_dp.sv
// Maximum-weight assignment by subset DP. Weight words load at one per cycle.
// A word with tlast starts the walk: each of the 2^n masks is scanned column by
// column (one column read per cycle from the weight and subset-best RAMs), then
// drained and written back; after the last mask the result is registered once the output is free.
// Input stalls during the walk. rst_n is synchronous: size returns to 16,
// control clears; RAM contents are not cleared.
module max_weight_assignment_subset_dp #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mwa_pkg::SIZE_W-1:0]          cfg_data,   // matrix_size
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mwa_pkg::IN_TDATA_W-1:0]      in_tdata,   // row_index, col_index, weight
  input  logic                                in_tlast,   // is_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mwa_pkg::OUT_TDATA_W-1:0]     out_tdata   // best_total, zero pad
);

  mwa_pkg::cmd_t             cmd;
  mwa_pkg::sts_t             sts;
  logic [mwa_pkg::OUT_W-1:0] best_total;

  assign cfg_ready = 1'b1;

  mwa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mwa_dp #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .row_index  (in_tdata[3:0]),
    .col_index  (in_tdata[7:4]),
    .weight     (in_tdata[39:8]),
    .cmd        (cmd),
    .sts        (sts),
    .best_total (best_total)
  );

  assign out_tdata = {{(mwa_pkg::OUT_TDATA_W - mwa_pkg::OUT_W){1'b0}}, best_total};

endmodule

FILE: rtl/core/mwa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mwa_ctrl.sv
// Sequencer for the subset DP: load, per-mask column scan, write-back, result.
// Depends on mwa_pkg.
module mwa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  mwa_pkg::sts_t sts,
  output mwa_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && in_tlast) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.col_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (sts.mask_last) begin
          state_nxt = S_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/mwa_dp.sv
// Datapath for the subset DP: weight and subset-best RAMs, mask/column counters,
// add-compare stage and result register. Depends on mwa_pkg and mwa_ram.
module mwa_dp #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [mwa_pkg::SIZE_W-1:0]          cfg_data,
  input  logic [mwa_pkg::IDX_W-1:0]           row_index,
  input  logic [mwa_pkg::IDX_W-1:0]           col_index,
  input  logic signed [mwa_pkg::WGT_W-1:0]    weight,
  input  mwa_pkg::cmd_t                       cmd,
  output mwa_pkg::sts_t                       sts,
  output logic [mwa_pkg::OUT_W-1:0]           best_total
);

  localparam int unsigned NW     = $clog2(MAX_SIZE + 1);
  localparam int unsigned CW     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned WDEPTH = MAX_SIZE * MAX_SIZE;
  localparam int unsigned WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned BDEPTH = 2 ** MAX_SIZE;
  localparam int unsigned BA     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int unsigned BEST_W = 31 + $clog2(MAX_SIZE);
  localparam int unsigned SW     = BEST_W + 2;

  logic [mwa_pkg::SIZE_W-1:0] size_r;
  logic [NW-1:0]              n_eff;
  logic [NW-1:0]              n_r;
  logic [MAX_SIZE-1:0]        mask_r, mask_nxt, full_mask, prev_mask, mask_inc;
  logic [CW-1:0]              col_r;
  logic [NW-1:0]              k_r, pc_r, krow;
  logic [BEST_W-1:0]          acc_r;
  logic                       v1_r;
  logic                       member;
  logic [mwa_pkg::OUT_W-1:0]  out_r;

  logic                       w_wr_en;
  logic [WA-1:0]              w_wr_addr, w_rd_addr;
  logic signed [mwa_pkg::WGT_W-1:0] w_rd_data;
  logic [BEST_W-1:0]          b_rd_data;
  logic signed [SW-1:0]       cand;

  // clamp size into 1..MAX_SIZE
  always_comb begin
    if (size_r == '0) begin
      n_eff = NW'(1);
    end else if (size_r > mwa_pkg::SIZE_W'(MAX_SIZE)) begin
      n_eff = NW'(MAX_SIZE);
    end else begin
      n_eff = NW'(size_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SIZE; i++) begin
      full_mask[i] = (i < int'(n_r));
    end
  end

  assign member    = mask_r[col_r];
  assign prev_mask = mask_r ^ (MAX_SIZE'(1) << col_r);
  assign mask_inc  = mask_r + MAX_SIZE'(1);
  assign krow      = (k_r == '0) ? '0 : k_r - NW'(1);

  assign sts.col_last  = (col_r == CW'(n_r - NW'(1)));
  assign sts.mask_last = (mask_r == full_mask);

  // weight store load port
  assign w_wr_en   = cmd.load && ({1'b0, row_index} < 5'(MAX_SIZE))
                     && ({1'b0, col_index} < 5'(MAX_SIZE));
  assign w_wr_addr = WA'(row_index) * WA'(MAX_SIZE) + WA'(col_index);
  assign w_rd_addr = WA'(krow) * WA'(MAX_SIZE) + WA'(col_r);

  mwa_ram #(
    .WIDTH (mwa_pkg::WGT_W),
    .DEPTH (WDEPTH)
  ) u_wgt_ram (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (weight),
    .rd_en   (cmd.issue),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data)
  );

  mwa_ram #(
    .WIDTH (BEST_W),
    .DEPTH (BDEPTH)
  ) u_best_ram (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (BA'(mask_r)),
    .wr_data (acc_r),
    .rd_en   (cmd.issue),
    .rd_addr (BA'(prev_mask)),
    .rd_data (b_rd_data)
  );

  assign cand = $signed({2'b00, b_rd_data}) + SW'(w_rd_data);

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.start) begin
      mask_nxt = '0;
    end else if (cmd.advance) begin
      mask_nxt = mask_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= mwa_pkg::SIZE_RESET;
      n_r    <= NW'(1);
      mask_r <= '0;
      col_r  <= '0;
      k_r    <= '0;
      pc_r   <= '0;
      acc_r  <= '0;
      v1_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        size_r <= cfg_data;
      end
      if (cmd.start) begin
        n_r <= n_eff;
      end
      mask_r <= mask_nxt;
      v1_r   <= cmd.issue && member;
      if (cmd.start || cmd.advance) begin
        col_r <= '0;
        k_r   <= cmd.start ? '0 : pc_r;
        pc_r  <= '0;
        acc_r <= '0;
      end else begin
        if (cmd.issue) begin
          col_r <= col_r + CW'(1);
          pc_r  <= pc_r + NW'(mask_inc[col_r]);
        end
        if (v1_r && (cand > $signed({2'b00, acc_r}))) begin
          acc_r <= cand[BEST_W-1:0];
        end
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= mwa_pkg::OUT_W'(acc_r);
    end
  end

  assign best_total = out_r;

endmodule

FILE: test/tb_max_weight_assignment_subset_dp.sv
// Testbench for max_weight_assignment_subset_dp: streams weight words, checks each
// best_total against a subset-DP predictor kept in step with accepted words.
// Depends on mwa_pkg and the block itself.
module tb_max_weight_assignment_subset_dp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_SIZE    = 16;
  localparam int unsigned STALL_LIMIT = 5_000_000;
  localparam int          WORD_TARGET = 1700;
  localparam logic signed [mwa_pkg::WGT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [mwa_pkg::WGT_W-1:0] W_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [mwa_pkg::IDX_W-1:0]        row;
    logic [mwa_pkg::IDX_W-1:0]        col;
    logic signed [mwa_pkg::WGT_W-1:0] weight;
    logic                             last;
  } weight_word_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mwa_pkg::SIZE_W-1:0]      cfg_data = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [mwa_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // row_index, col_index, weight
  logic                            in_tlast = 1'b0; // is_last
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mwa_pkg::OUT_TDATA_W-1:0] out_tdata;       // best_total, zero pad

  weight_word_t               words_to_send[$];
  logic [mwa_pkg::OUT_W-1:0]  totals_due[$];
  logic [mwa_pkg::SIZE_W-1:0] grid_size = mwa_pkg::SIZE_RESET;
  logic signed [mwa_pkg::WGT_W-1:0] weight_grid [MAX_SIZE][MAX_SIZE];
  longint            subset_total [0:(1 << MAX_SIZE) - 1];
  int                mismatches = 0;
  int                sent_words = 0;
  bit                steady = 1'b0;

  max_weight_assignment_subset_dp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int active_size();
    if (grid_size == 0) return 1;
    if (grid_size > MAX_SIZE) return MAX_SIZE;
    return int'(grid_size);
  endfunction

  // best[mask] = max(0, best[mask ^ (1 << c)] + w[popcount-1][c]) over member columns c
  function automatic logic [mwa_pkg::OUT_W-1:0] best_assignment_total();
    int          n;
    int          k;
    int unsigned full;
    longint      best;
    longint      cand;
    n    = active_size();
    full = (32'd1 << n) - 1;
    for (int unsigned mask = 0; mask <= full; mask++) begin
      k    = $countones(mask);
      best = 0;
      for (int c = 0; c < n; c++) begin
        if (((mask >> c) & 1) != 0) begin
          cand = subset_total[mask ^ (32'd1 << c)] + longint'(weight_grid[k-1][c]);
          if (cand > best) best = cand;
        end
      end
      subset_total[mask] = best;
    end
    return mwa_pkg::OUT_W'(subset_total[full]);
  endfunction

  function automatic void absorb_word(weight_word_t w);
    weight_grid[w.row][w.col] = w.weight;
    if (w.last) totals_due.insert(totals_due.size(), best_assignment_total());
  endfunction

  always @(posedge clk) begin : drive_words
    weight_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_word('{row: in_tdata[3:0], col: in_tdata[7:4],
                      weight: in_tdata[39:8], last: in_tlast});
      end
      if (!in_tvalid || in_tready) begin
        if (words_to_send.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
          nxt = words_to_send.pop_front();
          in_tdata  <= {nxt.weight, nxt.col, nxt.row};
          in_tlast  <= nxt.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_totals
    logic [mwa_pkg::OUT_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (totals_due.size() == 0) begin
          $error("best_total: no result expected, actual %0d",
                 out_tdata[mwa_pkg::OUT_W-1:0]);
          mismatches++;
        end else begin
          want = totals_due.pop_front();
          if (out_tdata[mwa_pkg::OUT_W-1:0] !== want) begin
            $error("best_total: expected %0d, actual %0d", want,
                   out_tdata[mwa_pkg::OUT_W-1:0]);
            mismatches++;
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= 14);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit link_busy();
    return words_to_send.size() != 0 || in_tvalid || totals_due.size() != 0;
  endfunction

  task automatic wait_idle();
    do begin
      while (link_busy()) @(posedge clk);
      repeat (8) @(posedge clk);
    end while (link_busy());
  endtask

  task automatic set_size(input logic [mwa_pkg::SIZE_W-1:0] value);
    wait_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    grid_size = value;
  endtask

  task automatic push_word(input int r, input int c,
                           input logic signed [mwa_pkg::WGT_W-1:0] w, input bit last);
    words_to_send.insert(words_to_send.size(),
                         weight_word_t'{row: mwa_pkg::IDX_W'(r), col: mwa_pkg::IDX_W'(c),
                                        weight: w, last: last});
    sent_words++;
  endtask

  function automatic logic signed [mwa_pkg::WGT_W-1:0] pick_weight(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(400)) - 200;
      default: begin
        case ($urandom_range(4))
          0: return W_MAX;
          1: return W_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // every cell of the n-by-n corner in shuffled order, none flagged last
  task automatic load_block(input int n, input int mode);
    int cells[$];
    int j;
    int t;
    for (int i = 0; i < n * n; i++) cells.insert(cells.size(), i);
    for (int i = n * n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = cells[i];
      cells[i] = cells[j];
      cells[j] = t;
    end
    foreach (cells[i]) push_word(cells[i] / n, cells[i] % n, pick_weight(mode), 1'b0);
  endtask

  initial begin : stimulus
    int n;
    int mode;
    int kind;
    int phase;
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // size above range behaves as 16; all-max matrix gives the largest total
    set_size(5'd31);
    for (int r = 0; r < MAX_SIZE; r++)
      for (int c = 0; c < MAX_SIZE; c++)
        push_word(r, c, W_MAX, r == MAX_SIZE - 1 && c == MAX_SIZE - 1);

    // size zero behaves as one
    set_size(5'd0);
    push_word(0, 0, W_MAX, 1'b1);
    push_word(0, 0, W_MIN, 1'b1);
    push_word(0, 0, 0, 1'b1);
    push_word(0, 0, -1, 1'b1);
    push_word(15, 15, W_MIN, 1'b0);
    push_word(9, 3, 32'sh5A5A_A5A5, 1'b1);
    push_word(0, 0, 1, 1'b1);

    set_size(5'd1);
    push_word(0, 0, 32'sh0001_E240, 1'b1);
    push_word(7, 12, W_MAX, 1'b1);

    set_size(5'd2);
    push_word(0, 0, 5, 1'b0);
    push_word(0, 1, -3, 1'b0);
    push_word(1, 0, -7, 1'b0);
    push_word(1, 1, 10, 1'b1);
    push_word(1, 1, W_MIN, 1'b1);
    push_word(0, 0, W_MIN, 1'b0);
    push_word(0, 1, W_MIN, 1'b0);
    push_word(1, 0, W_MIN, 1'b1);

    phase = 0;
    while (sent_words < WORD_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 5)       set_size(5'd0);
      else if (pick < 80) set_size(mwa_pkg::SIZE_W'($urandom_range(1, 6)));
      else if (pick < 96) set_size(mwa_pkg::SIZE_W'($urandom_range(7, 9)));
      else                set_size(5'd10);
      steady = (phase == 3);
      n = active_size();
      repeat ($urandom_range(2, 5)) begin
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        mode = (pick < 50) ? 0 : (pick < 80) ? 1 : 2;
        if (kind < 65) begin
          load_block(n, mode);
          push_word($urandom_range(n - 1), $urandom_range(n - 1), pick_weight(mode), 1'b1);
        end else if (kind < 85) begin
          repeat ($urandom_range(1, n * n))
            push_word($urandom_range(n - 1), $urandom_range(n - 1), pick_weight(mode), 1'b0);
          push_word($urandom_range(15), $urandom_range(15), pick_weight(mode), 1'b1);
        end else begin
          repeat ($urandom_range(1, 8))
            push_word($urandom_range(15), $urandom_range(15), pick_weight(mode), 1'b0);
        end
      end
      phase++;
    end

    wait_idle();
    steady = 1'b0;
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: max_weight_assignment_subset_dp.f
rtl/core/mwa_pkg.sv
rtl/core/mwa_ram.sv
rtl/core/mwa_ctrl.sv
rtl/core/mwa_dp.sv
rtl/core/max_weight_assignment_subset_dp.sv
test/tb_max_weight_assignment_subset_dp.sv
